// ----- hw/rtl/fdl_pkg.sv -----
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants of the fractional delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int DELAY_BITS  = 18;
    localparam int RING_DEPTH  = 1024;
    localparam int ADDR_BITS   = $clog2(RING_DEPTH);
    localparam int GUARD_TAPS  = 8;
    localparam int ROUND_HALF  = 2 ** (FRAC_BITS - 1);
    localparam int ROUND_ONE   = 2 ** FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DELAY_BITS-1:0]         delay_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;
    typedef logic [FRAC_BITS-1:0]          frac_t;

    localparam delay_t DELAY_MAX = delay_t'((RING_DEPTH - GUARD_TAPS) * ROUND_ONE);

    typedef enum logic {
        MODE_LINEAR = 1'b0,
        MODE_CUBIC  = 1'b1
    } interp_mode_t;

    // Ring write and read requests
    typedef struct packed {
        logic    we;
        addr_t   addr;
        sample_t data;
    } ring_wr_t;

    typedef struct packed {
        logic  re;
        addr_t addr;
    } ring_rd_t;

    // Taps around the read point: y0 = ring[k+1] ... y3 = ring[k-2]
    typedef struct packed {
        sample_t y0;
        sample_t y1;
        sample_t y2;
        sample_t y3;
    } fdl_taps_t;

    typedef struct packed {
        logic         start;
        interp_mode_t mode;
        frac_t        frac;
    } fdl_calc_ctl_t;

endpackage

// ----- hw/rtl/fdl_if.sv -----
// ----------------------------------------------------------------------------
// fdl_in_if / fdl_out_if
// Valid/ready stream channels for samples in and interpolated samples out.
// ----------------------------------------------------------------------------
interface fdl_in_if import fdl_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_in;
    delay_t  delay_amount;

    modport source (output valid, output sample_in, output delay_amount, input ready);
    modport sink   (input valid, input sample_in, input delay_amount, output ready);
endinterface

interface fdl_out_if import fdl_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/fdl_ring.sv -----
// ----------------------------------------------------------------------------
// fdl_ring
// Sample ring: one write port, one registered read port. Entries not yet
// written since reset read as zero, tracked by the fill position.
// ----------------------------------------------------------------------------
module fdl_ring import fdl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ring_wr_t wr,
    input  ring_rd_t rd,
    output sample_t  rdata
);

    sample_t ring_mem [RING_DEPTH];

    logic    full_reg;
    logic    written_reg;
    addr_t   last_waddr_reg;
    sample_t mem_q_reg;
    logic    zero_q_reg;
    logic    entry_valid;

    // writes run strictly in address order from zero, so an entry is filled
    // once the ring has wrapped or it lies at or below the last write
    assign entry_valid = full_reg || (written_reg && (rd.addr <= last_waddr_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg       <= 1'b0;
            written_reg    <= 1'b0;
            last_waddr_reg <= '0;
        end
        else if (wr.we)
        begin
            written_reg    <= 1'b1;
            last_waddr_reg <= wr.addr;
            if (wr.addr == addr_t'(RING_DEPTH - 1))
            begin
                full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            ring_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            mem_q_reg  <= ring_mem[rd.addr];
            zero_q_reg <= !entry_valid;
        end
    end

    assign rdata = zero_q_reg ? sample_t'(0) : mem_q_reg;

endmodule

// ----- hw/rtl/fdl_interp.sv -----
// ----------------------------------------------------------------------------
// fdl_interp
// Three-stage fixed-point interpolator: linear or 4-point Hermite, with
// half-up rounding per stage and output saturation.
// ----------------------------------------------------------------------------
module fdl_interp import fdl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  fdl_calc_ctl_t ctl,
    input  fdl_taps_t     taps,
    output logic          done,
    output sample_t       result
);

    localparam int RES_BITS = 24;

    function automatic sample_t sat_sample(logic signed [RES_BITS-1:0] v);
        logic signed [RES_BITS-1:0] hi;
        logic signed [RES_BITS-1:0] lo;
        hi = RES_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
        lo = -hi - RES_BITS'(1);
        if (v > hi)
        begin
            return sample_t'(hi);
        end
        else if (v < lo)
        begin
            return sample_t'(lo);
        end
        return sample_t'(v);
    endfunction

    // stage 1 terms
    logic signed [FRAC_BITS:0] fs1;
    logic signed [16:0]        a1;
    logic signed [19:0]        b1;
    logic signed [19:0]        d12;
    logic signed [19:0]        c1;
    logic signed [28:0]        s1;
    logic signed [16:0]        dl;
    logic signed [25:0]        sl;

    logic                      v1_reg;
    interp_mode_t              mode1_reg;
    frac_t                     frac1_reg;
    logic signed [21:0]        r1_reg;
    logic signed [16:0]        a1_reg;
    sample_t                   y1_1_reg;
    logic signed [17:0]        lin1_reg;

    // stage 2
    logic signed [FRAC_BITS:0] fs2;
    logic signed [31:0]        s2;

    logic                      v2_reg;
    interp_mode_t              mode2_reg;
    frac_t                     frac2_reg;
    logic signed [21:0]        r2_reg;
    sample_t                   y1_2_reg;
    logic signed [17:0]        lin2_reg;

    // stage 3
    logic signed [FRAC_BITS:0] fs3;
    logic signed [31:0]        s3;
    logic signed [RES_BITS-1:0] cres;
    logic signed [RES_BITS-1:0] fres;

    logic                      done_reg;
    sample_t                   result_reg;

    always_comb
    begin
        fs1 = signed'({1'b0, ctl.frac});
        a1  = 17'(taps.y2) - 17'(taps.y0);
        b1  = (20'(taps.y0) <<< 1) - (20'(taps.y1) <<< 2) - 20'(taps.y1)
              + (20'(taps.y2) <<< 2) - 20'(taps.y3);
        d12 = 20'(taps.y1) - 20'(taps.y2);
        c1  = (d12 <<< 1) + d12 + 20'(taps.y3) - 20'(taps.y0);
        s1  = 29'(c1) * 29'(fs1) + (29'(b1) <<< FRAC_BITS) + 29'(ROUND_HALF);
        dl  = 17'(taps.y2) - 17'(taps.y1);
        sl  = 26'(dl) * 26'(fs1) + 26'(ROUND_HALF);
    end

    always_comb
    begin
        fs2 = signed'({1'b0, frac1_reg});
        s2  = 32'(r1_reg) * 32'(fs2) + (32'(a1_reg) <<< FRAC_BITS) + 32'(ROUND_HALF);
    end

    always_comb
    begin
        fs3  = signed'({1'b0, frac2_reg});
        s3   = 32'(r2_reg) * 32'(fs3) + 32'(ROUND_ONE);
        cres = RES_BITS'(y1_2_reg) + RES_BITS'(s3 >>> (FRAC_BITS + 1));
        fres = (mode2_reg == MODE_CUBIC) ? cres : RES_BITS'(lin2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctl.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mode1_reg <= ctl.mode;
            frac1_reg <= ctl.frac;
            r1_reg    <= 22'(s1 >>> FRAC_BITS);
            a1_reg    <= a1;
            y1_1_reg  <= taps.y1;
            lin1_reg  <= 18'(taps.y1) + 18'(sl >>> FRAC_BITS);
        end
        if (v1_reg)
        begin
            mode2_reg <= mode1_reg;
            frac2_reg <= frac1_reg;
            r2_reg    <= 22'(s2 >>> FRAC_BITS);
            y1_2_reg  <= y1_1_reg;
            lin2_reg  <= lin1_reg;
        end
        if (v2_reg)
        begin
            result_reg <= sat_sample(fres);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hw/rtl/fractional_delay_line_unit.sv -----
// ----------------------------------------------------------------------------
// fractional_delay_line_unit
// Flow: one item in flight; a new input beat is taken only once the result
//   has been loaded into the output register, which waits while the output
//   stalls. Each item's pass is set by the single ring read port (one tap per
//   cycle; two taps linear, four cubic) plus the three-stage interpolator.
// Reset: write position, mode and control clear at once; the ring reads as
//   zero until each entry is written (fill tracking, no clearing sweep).
// ----------------------------------------------------------------------------
module fractional_delay_line_unit import fdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fdl_in_if.sink      sample_ch,
    fdl_out_if.source   result_ch,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    addr_t        wp_reg, wp_next;
    interp_mode_t mode_reg;
    interp_mode_t item_mode_reg, item_mode_next;
    frac_t        frac_reg, frac_next;
    addr_t        base_reg, base_next;
    logic [1:0]   rd_cnt_reg, rd_cnt_next;
    logic         rd_pend_reg, rd_pend_next;
    logic [1:0]   rd_idx_reg, rd_idx_next;
    logic         rd_last_reg, rd_last_next;
    logic         start_reg;
    fdl_taps_t    taps_reg;
    logic         out_valid_reg, out_valid_next;
    sample_t      out_data_reg;

    logic          accept;
    logic          out_load;
    delay_t        delay_sat;
    logic [1:0]    last_idx;
    ring_wr_t      ring_wr;
    ring_rd_t      ring_rd;
    sample_t       ring_rdata;
    fdl_calc_ctl_t calc_ctl;
    logic          calc_done;
    sample_t       calc_result;

    assign accept          = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == S_IDLE);

    // delays past the guarded ring length clamp to the maximum
    assign delay_sat = (sample_ch.delay_amount > DELAY_MAX) ? DELAY_MAX
                                                            : sample_ch.delay_amount;

    // linear uses taps k and k-1 (indexes 1, 2); cubic walks k+1 .. k-2
    assign last_idx = (item_mode_reg == MODE_CUBIC) ? 2'd3 : 2'd2;

    // the new sample lands at the accept edge, ahead of any tap read
    always_comb
    begin
        ring_wr.we   = accept;
        ring_wr.addr = wp_reg;
        ring_wr.data = sample_ch.sample_in;
    end

    always_comb
    begin
        ring_rd.re   = (state_reg == S_READ);
        ring_rd.addr = base_reg + addr_t'(1) - addr_t'(rd_cnt_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        item_mode_next = item_mode_reg;
        frac_next      = frac_reg;
        base_next      = base_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_cnt_reg;
        rd_last_next   = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next        = wp_reg + addr_t'(1);
                    item_mode_next = mode_reg;
                    frac_next      = delay_sat[FRAC_BITS-1:0];
                    base_next      = wp_reg - addr_t'(delay_sat >> FRAC_BITS);
                    rd_cnt_next    = (mode_reg == MODE_CUBIC) ? 2'd0 : 2'd1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                rd_pend_next = 1'b1;
                rd_last_next = (rd_cnt_reg == last_idx);
                rd_cnt_next  = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == last_idx)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (calc_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            mode_reg      <= MODE_LINEAR;
            item_mode_reg <= MODE_LINEAR;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            rd_last_reg   <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            item_mode_reg <= item_mode_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            rd_last_reg   <= rd_last_next;
            start_reg     <= rd_pend_reg && rd_last_reg;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= interp_mode_t'(cfg_wdata);
            end
        end
    end

    // payload: delay fields, taps and output data
    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
        base_reg <= base_next;
        if (rd_pend_reg)
        begin
            case (rd_idx_reg)
                2'd0:    taps_reg.y0 <= ring_rdata;
                2'd1:    taps_reg.y1 <= ring_rdata;
                2'd2:    taps_reg.y2 <= ring_rdata;
                default: taps_reg.y3 <= ring_rdata;
            endcase
        end
        if (out_load)
        begin
            out_data_reg <= calc_result;
        end
    end

    always_comb
    begin
        calc_ctl.start = start_reg;
        calc_ctl.mode  = item_mode_reg;
        calc_ctl.frac  = frac_reg;
    end

    fdl_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (ring_wr),
        .rd    (ring_rd),
        .rdata (ring_rdata)
    );

    fdl_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (calc_ctl),
        .taps   (taps_reg),
        .done   (calc_done),
        .result (calc_result)
    );

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_data_reg;

endmodule

// ----- hw/rtl/fdl_checker.sv -----
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the delay line handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module fdl_checker import fdl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_ready,
    input  logic    out_valid,
    input  logic    out_ready,
    input  sample_t out_data
);

    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // a stalled output beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // a stalled output beat keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output data changed while stalled");

    // one item in flight: input closes right after a beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("input reopened while an item is in flight");

    // a fresh result comes out as the block frees up
    a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result issued while still busy");

    // an accepted item never yields a result on the next edge
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind fractional_delay_line_unit fdl_checker u_fdl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_data  (result_ch.sample_out)
);

// ----- tb/sv/fractional_delay_line_unit_test.sv -----
// ----------------------------------------------------------------------------
// fractional_delay_line_unit_test
// Self-checking bench for the fractional delay line. Drives sample/delay beats
// with random gaps, keeps its own copy of the ring and the interpolator, and
// compares every output beat against the predicted sample. Both linear and
// cubic Hermite modes are run, with directed edge cases first, then random
// streams of noise and smooth swept-delay bursts.
// ----------------------------------------------------------------------------
module fractional_delay_line_unit_test;
    import fdl_pkg::*;

    // Run limit: sized for the worst case per beat (longest idle on input, the
    // pass through the block, longest stall on output) over ~1400 beats, plus
    // drains. Taken several times over.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Cubic path is the slower one; leave margin after a drain.
    localparam int unsigned IDLE_GUARD  = 24;
    localparam int unsigned GAP_MAX     = 13;
    localparam int          SAMPLE_HI   = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int          SAMPLE_LO   = -(2 ** (SAMPLE_BITS - 1));
    localparam int          DELAY_TOP   = 2 ** DELAY_BITS - 1;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fdl_in_if  sample_ch ();
    fdl_out_if result_ch ();

    fractional_delay_line_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the ring, write pointer and mode.
    // ------------------------------------------------------------------------
    sample_t      ring_copy [RING_DEPTH];
    addr_t        write_ptr;
    interp_mode_t active_mode;

    // Output samples predicted but not yet seen on result_ch, oldest first.
    sample_t      pending_outputs [$];

    // Upper bounds of the per-beat idle draws; zero gives a stretch with no idling on that side.
    int unsigned  tx_gap_max;
    int unsigned  rx_gap_max;

    int unsigned  beats_sent;
    int unsigned  cubic_beats;
    int unsigned  clipped_delays;
    int unsigned  outputs_checked;
    int unsigned  mode_writes;
    int unsigned  error_count;
    int unsigned  cycle_count;

    // Store the new sample, then interpolate around the tap k = wp - floor(delay).
    function automatic sample_t interpolate_tap(sample_t s, delay_t d);
        delay_t dly;
        addr_t  k;
        addr_t  k_next;
        addr_t  k_prev;
        addr_t  k_prev2;
        longint f;
        longint y0;
        longint y1;
        longint y2;
        longint y3;
        longint a;
        longint b;
        longint c;
        longint r1;
        longint r2;
        longint acc;

        ring_copy[write_ptr] = s;

        // Delays past the ring guard clip to the longest legal delay.
        dly     = (d > DELAY_MAX) ? DELAY_MAX : d;
        f       = longint'(dly[FRAC_BITS-1:0]);
        k       = write_ptr - addr_t'(dly >> FRAC_BITS);
        k_next  = k + addr_t'(1);
        k_prev  = k - addr_t'(1);
        k_prev2 = k - addr_t'(2);

        if (active_mode == MODE_LINEAR)
        begin
            y0  = ring_copy[k];
            y1  = ring_copy[k_prev];
            acc = y0 + (((y1 - y0) * f + ROUND_HALF) >>> FRAC_BITS);
        end
        else
        begin
            // With zero integer delay k_next is the oldest slot in the ring.
            y0  = ring_copy[k_next];
            y1  = ring_copy[k];
            y2  = ring_copy[k_prev];
            y3  = ring_copy[k_prev2];
            a   = y2 - y0;
            b   = 2 * y0 - 5 * y1 + 4 * y2 - y3;
            c   = 3 * (y1 - y2) + y3 - y0;
            r1  = (c * f + b * ROUND_ONE + ROUND_HALF) >>> FRAC_BITS;
            r2  = (r1 * f + a * ROUND_ONE + ROUND_HALF) >>> FRAC_BITS;
            acc = y1 + ((r2 * f + ROUND_ONE) >>> (FRAC_BITS + 1));
        end

        if (acc > SAMPLE_HI)
            acc = SAMPLE_HI;
        else if (acc < SAMPLE_LO)
            acc = SAMPLE_LO;

        write_ptr = write_ptr + addr_t'(1);
        return sample_t'(acc);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. All are entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_beat(sample_t s, delay_t d);
        int unsigned gap;

        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_in    <= s;
        sample_ch.delay_amount <= d;
        do @(posedge clk); while (!sample_ch.ready);

        // Beat taken at this edge: predict with the values just accepted.
        pending_outputs.push_back(interpolate_tap(s, d));
        beats_sent++;
        if (d > DELAY_MAX)
            clipped_delays++;
        if (active_mode == MODE_CUBIC)
            cubic_beats++;
        @(negedge clk);
    endtask

    // Hold off input until every predicted output has come out, then let the
    // pipeline settle.
    task automatic drain_outputs();
        sample_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (IDLE_GUARD) @(negedge clk);
    endtask

    // Mode changes only while the block is idle.
    task automatic set_interp_mode(interp_mode_t m);
        drain_outputs();
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(posedge clk);
        active_mode = m;
        mode_writes++;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic sample_t pick_sample();
        int unsigned pick;

        pick = $urandom_range(0, 9);
        if (pick < 6)
            return sample_t'($urandom);
        else if (pick < 8)
            return sample_t'(int'($urandom_range(0, 511)) - 256);
        else if (pick == 8)
            return sample_t'(SAMPLE_HI);
        else
            return sample_t'(SAMPLE_LO);
    endfunction

    function automatic delay_t pick_delay();
        int unsigned pick;

        pick = $urandom_range(0, 9);
        if (pick < 4)
            return delay_t'($urandom_range(0, 2047));          // short taps
        else if (pick < 7)
            return delay_t'($urandom_range(0, DELAY_MAX));     // anywhere legal
        else if (pick == 7)
            return delay_t'($urandom_range(DELAY_MAX - 300, DELAY_MAX));
        else if (pick == 8)
            return delay_t'($urandom_range(DELAY_MAX + 1, DELAY_TOP));
        else
            return delay_t'($urandom);
    endfunction

    // Smooth signal with a slowly swept delay, as a modulated delay effect
    // would produce: exercises interpolation between correlated neighbors.
    task automatic send_sweep(int unsigned len);
        int level;
        int dly;
        int dly_step;
        int amp;

        level    = int'(pick_sample());
        dly      = int'(pick_delay());
        dly_step = int'($urandom_range(0, 96)) - 48;
        amp      = int'($urandom_range(16, 6000));
        repeat (len)
        begin
            level = level + int'($urandom_range(0, 2 * amp)) - amp;
            if (level > SAMPLE_HI)
                level = SAMPLE_HI;
            else if (level < SAMPLE_LO)
                level = SAMPLE_LO;
            dly = dly + dly_step;
            if (dly < 0)
                dly = 0;
            else if (dly > DELAY_TOP)
                dly = DELAY_TOP;
            send_beat(sample_t'(level), delay_t'(dly));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Linear mode from reset: full-scale samples, zero and maximum fraction,
    // reads of slots still holding their cleared value, clipped delays.
    task automatic test_linear_edges();
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        send_beat(sample_t'(SAMPLE_HI), delay_t'(0));
        send_beat(sample_t'(SAMPLE_LO), delay_t'(0));
        send_beat(sample_t'(SAMPLE_LO), delay_t'(128));
        send_beat(sample_t'(SAMPLE_HI), delay_t'(255));
        send_beat(sample_t'(0), delay_t'(256));
        send_beat(sample_t'(-1), DELAY_MAX);
        send_beat(sample_t'(12345), DELAY_MAX + delay_t'(1));
        send_beat(sample_t'(-12345), delay_t'(DELAY_TOP));
        send_beat(sample_t'(1), delay_t'(18'h2AAAA));
        send_beat(sample_t'(-2), delay_t'(18'h15555));
    endtask

    // Cubic mode: zero integer delay reaching the oldest slot, alternating
    // full-scale samples to push the Hermite kernel into clipping.
    task automatic test_cubic_edges();
        set_interp_mode(MODE_CUBIC);
        send_beat(sample_t'(SAMPLE_HI), delay_t'(0));
        send_beat(sample_t'(SAMPLE_LO), delay_t'(0));
        send_beat(sample_t'(SAMPLE_HI), delay_t'(128));
        send_beat(sample_t'(SAMPLE_LO), delay_t'(128));
        send_beat(sample_t'(SAMPLE_HI), delay_t'(64));
        send_beat(sample_t'(SAMPLE_LO), delay_t'(192));
        send_beat(sample_t'(0), delay_t'(255));
        send_beat(sample_t'(100), delay_t'(384));
        send_beat(sample_t'(-100), DELAY_MAX);
        send_beat(sample_t'(7), delay_t'(DELAY_TOP));
        send_beat(sample_t'(-7), delay_t'(3));
    endtask

    // Random stream in one mode: mostly swept bursts, some raw noise; idling
    // switched on and off in stretches, with a full drain now and then.
    task automatic test_random_stream(interp_mode_t m, int unsigned count);
        int unsigned sent;
        int unsigned len;
        int unsigned next_shuffle;
        int unsigned next_drain;

        set_interp_mode(m);
        sent         = 0;
        next_shuffle = 0;
        next_drain   = 120;
        while (sent < count)
        begin
            if (sent >= next_shuffle)
            begin
                tx_gap_max   = ($urandom_range(0, 3) != 0) ? GAP_MAX : 0;
                rx_gap_max   = ($urandom_range(0, 3) != 0) ? GAP_MAX : 0;
                next_shuffle = sent + 50;
            end
            if (sent >= next_drain)
            begin
                drain_outputs();
                next_drain = sent + 120;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                len = $urandom_range(8, 40);
                send_sweep(len);
                sent += len;
            end
            else
            begin
                send_beat(pick_sample(), pick_delay());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: per-beat stall draw, then ready held until the handshake.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;

        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, rx_gap_max);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    // Compare every output beat with the oldest prediction.
    always @(posedge clk)
    begin
        sample_t want;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: sample_out beat %0d with no prediction pending",
                         $time, result_ch.sample_out);
                error_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                outputs_checked++;
                if (result_ch.sample_out !== want)
                begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, want, result_ch.sample_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d outputs still pending",
                 cycle_count, pending_outputs.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_in    <= '0;
        sample_ch.delay_amount <= '0;

        // Reset state: ring cleared, pointer at zero, linear mode.
        foreach (ring_copy[i])
            ring_copy[i] = '0;
        write_ptr       = '0;
        active_mode     = MODE_LINEAR;
        tx_gap_max      = GAP_MAX;
        rx_gap_max      = GAP_MAX;
        beats_sent      = 0;
        cubic_beats     = 0;
        clipped_delays  = 0;
        outputs_checked = 0;
        mode_writes     = 0;
        error_count     = 0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_linear_edges();
        test_cubic_edges();
        test_random_stream(MODE_LINEAR, 325);
        test_random_stream(MODE_CUBIC, 325);
        test_random_stream(MODE_LINEAR, 325);
        test_random_stream(MODE_CUBIC, 325);
        drain_outputs();

        $display("Sent %0d beats (%0d cubic, %0d with delay past the limit), %0d outputs compared",
                 beats_sent, cubic_beats, clipped_delays, outputs_checked);
        $display("Mode register written %0d times, ring wrapped %0d times",
                 mode_writes, beats_sent / RING_DEPTH);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- fractional_delay_line_unit.f -----
hw/rtl/fdl_pkg.sv
hw/rtl/fdl_if.sv
hw/rtl/fdl_ring.sv
hw/rtl/fdl_interp.sv
hw/rtl/fractional_delay_line_unit.sv
hw/rtl/fdl_checker.sv
tb/sv/fractional_delay_line_unit_test.sv
